// ===== design/pcmrq_pkg.sv =====
// pcmrq_pkg: shared types, codes and constants for the noise-shaped pcm requantizer
// used by pcmrq_quant and pcm_requantizer_noise_shaped; no dependencies
package pcmrq_pkg;

    localparam int GUARD_WIDTH = 3;
    localparam int SAMPLE_W    = 32;
    localparam int CODE_W      = 16;
    localparam int TAP_W       = 8;
    localparam int TAPS        = 4;
    localparam int FMT_W       = 3;
    localparam int REG_IDX_W   = 3;

    // arithmetic shift for the 8-bit and the 16-bit paths
    localparam int SHIFT8  = 32 - 8 - GUARD_WIDTH;
    localparam int SHIFT16 = 32 - 16 - GUARD_WIDTH;

    // output format codes
    localparam logic [FMT_W-1:0] FMT_S8       = 3'd0;
    localparam logic [FMT_W-1:0] FMT_U8       = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S16      = 3'd2;
    localparam logic [FMT_W-1:0] FMT_U16      = 3'd3;
    localparam logic [FMT_W-1:0] FMT_S16_SWAP = 3'd4;
    localparam logic [FMT_W-1:0] FMT_U16_SWAP = 3'd5;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FORMAT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHAPING = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MONO    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAP_A   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TAP_B   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TAP_C   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TAP_D   = 3'd6;

    localparam logic signed [SAMPLE_W-1:0] SAT8_MAX  = 32'sd127;
    localparam logic signed [SAMPLE_W-1:0] SAT8_MIN  = -32'sd128;
    localparam logic signed [SAMPLE_W-1:0] SAT16_MAX = 32'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAT16_MIN = -32'sd32768;
    localparam logic [7:0]  OFFSET8  = 8'h80;
    localparam logic [15:0] OFFSET16 = 16'h8000;

    typedef logic [TAPS-1:0][SAMPLE_W-1:0] t_hist;

    typedef struct packed {
        logic [FMT_W-1:0]                     fmt;
        logic                                 shaping;
        logic                                 mono;
        logic [TAPS-1:0][TAP_W-1:0]           taps;   // index 0 is the newest error
    } t_cfg;

endpackage

// ===== design/pcm_requantizer_noise_shaped.sv =====
// pcm_requantizer_noise_shaped: top level with register file, pipeline and error histories
// depends on pcmrq_pkg and pcmrq_quant
//
// Takes one signed 32-bit mixing sample per request and returns one 8-bit or 16-bit code.
// One request is accepted every clock cycle while the output is not stalled; a result appears
// on the outputs when the result register loads from the input register. The error feedback
// loop, four 8x32 multiplies, their sum, the shift, clip and error subtract, is combinational
// from the input register to the history registers, which sets the clock rate. Left and right
// histories alternate in stereo mode and return to left after a block end. The user must write
// the registers through the configuration port only while no request is in flight; the block
// itself does not enforce this. o_cfg_ready is always high.
module pcm_requantizer_noise_shaped (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [pcmrq_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_block_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [pcmrq_pkg::CODE_W-1:0]         o_code_out,
    output logic                                 o_last_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcmrq_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcmrq_pkg::TAP_W-1:0]          i_cfg_data
);

    pcmrq_pkg::t_cfg                 r_cfg;
    pcmrq_pkg::t_hist                r_hist_l;
    pcmrq_pkg::t_hist                r_hist_r;
    logic                            r_phase;
    logic                            r_s1_valid;
    logic [pcmrq_pkg::SAMPLE_W-1:0]  r_s1_sample;
    logic                            r_s1_last;
    logic                            r_out_valid;
    logic [pcmrq_pkg::CODE_W-1:0]    r_code;
    logic                            r_last;

    logic                            in_acc;
    logic                            advance;
    logic                            use_left;
    logic                            n_phase;
    pcmrq_pkg::t_hist                hist_sel;
    pcmrq_pkg::t_hist                n_hist;
    logic [pcmrq_pkg::CODE_W-1:0]    q_code;
    logic                            q_shaped;
    logic [pcmrq_pkg::SAMPLE_W-1:0]  q_err;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !advance;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign use_left = r_cfg.mono || !r_phase;
    assign hist_sel = use_left ? r_hist_l : r_hist_r;
    assign n_hist   = {hist_sel[2], hist_sel[1], hist_sel[0], q_err};
    assign n_phase  = (r_cfg.mono || r_s1_last) ? 1'b0 : !r_phase;

    pcmrq_quant u_quant (
        .i_cfg    (r_cfg),
        .i_sample (r_s1_sample),
        .i_hist   (hist_sel),
        .o_code   (q_code),
        .o_shaped (q_shaped),
        .o_err    (q_err)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt     <= pcmrq_pkg::FMT_S16;
            r_cfg.shaping <= 1'b0;
            r_cfg.mono    <= 1'b0;
            r_cfg.taps    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcmrq_pkg::REG_FORMAT: begin
                    if (i_cfg_data[pcmrq_pkg::FMT_W-1:0] <= pcmrq_pkg::FMT_U16_SWAP) begin
                        r_cfg.fmt <= i_cfg_data[pcmrq_pkg::FMT_W-1:0];
                    end
                end
                pcmrq_pkg::REG_SHAPING: r_cfg.shaping <= i_cfg_data[0];
                pcmrq_pkg::REG_MONO:    r_cfg.mono    <= i_cfg_data[0];
                pcmrq_pkg::REG_TAP_A:   r_cfg.taps[0] <= i_cfg_data;
                pcmrq_pkg::REG_TAP_B:   r_cfg.taps[1] <= i_cfg_data;
                pcmrq_pkg::REG_TAP_C:   r_cfg.taps[2] <= i_cfg_data;
                pcmrq_pkg::REG_TAP_D:   r_cfg.taps[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control, phase and histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_hist_l    <= '0;
            r_hist_r    <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
                if (q_shaped) begin
                    if (use_left) begin
                        r_hist_l <= n_hist;
                    end else begin
                        r_hist_r <= n_hist;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_sample_in;
            r_s1_last   <= i_block_end;
        end
        if (advance) begin
            r_code <= q_code;
            r_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code_out  = r_code;
    assign o_last_out  = r_last;

    a_block_end_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_last |=> !r_phase)
        else $error("channel phase not back to left after block end");

    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && q_shaped) |=> $stable(r_hist_l) && $stable(r_hist_r))
        else $error("history changed without a shaped sample");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_byte_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && q_shaped |-> q_code[15:8] == 8'h00)
        else $error("8-bit code with nonzero high byte");

endmodule

// ===== design/pcmrq_quant.sv =====
// pcmrq_quant: combinational requantizer with 4-tap error feedback
// depends on pcmrq_pkg
module pcmrq_quant (
    input  pcmrq_pkg::t_cfg                       i_cfg,
    input  logic [pcmrq_pkg::SAMPLE_W-1:0]        i_sample,
    input  pcmrq_pkg::t_hist                      i_hist,
    output logic [pcmrq_pkg::CODE_W-1:0]          o_code,
    output logic                                  o_shaped,
    output logic [pcmrq_pkg::SAMPLE_W-1:0]        o_err
);

    logic                                  fmt8;
    logic signed [pcmrq_pkg::SAMPLE_W-1:0] prod [pcmrq_pkg::TAPS];
    logic [pcmrq_pkg::SAMPLE_W-1:0]        fb_sum;
    logic signed [pcmrq_pkg::SAMPLE_W-1:0] acc;
    logic signed [pcmrq_pkg::SAMPLE_W-1:0] sh8;
    logic signed [pcmrq_pkg::SAMPLE_W-1:0] sh16;
    logic signed [pcmrq_pkg::SAMPLE_W-1:0] sat8;
    logic signed [pcmrq_pkg::SAMPLE_W-1:0] sat16;
    logic [7:0]                            c8;
    logic [15:0]                           c16;

    assign fmt8     = (i_cfg.fmt == pcmrq_pkg::FMT_S8) || (i_cfg.fmt == pcmrq_pkg::FMT_U8);
    assign o_shaped = fmt8 && i_cfg.shaping;

    // products wrap to 32 bits
    always_comb begin
        for (int k = 0; k < pcmrq_pkg::TAPS; k++) begin
            prod[k] = pcmrq_pkg::SAMPLE_W'(
                pcmrq_pkg::SAMPLE_W'($signed(i_cfg.taps[k])) * $signed(i_hist[k]));
        end
    end

    assign fb_sum = prod[0] + prod[1] + prod[2] + prod[3];
    assign acc    = $signed(i_sample + (o_shaped ? fb_sum : '0));
    assign sh8    = acc >>> pcmrq_pkg::SHIFT8;
    assign sh16   = $signed(i_sample) >>> pcmrq_pkg::SHIFT16;

    always_comb begin
        if (sh8 > pcmrq_pkg::SAT8_MAX) begin
            sat8 = pcmrq_pkg::SAT8_MAX;
        end else if (sh8 < pcmrq_pkg::SAT8_MIN) begin
            sat8 = pcmrq_pkg::SAT8_MIN;
        end else begin
            sat8 = sh8;
        end
        if (sh16 > pcmrq_pkg::SAT16_MAX) begin
            sat16 = pcmrq_pkg::SAT16_MAX;
        end else if (sh16 < pcmrq_pkg::SAT16_MIN) begin
            sat16 = pcmrq_pkg::SAT16_MIN;
        end else begin
            sat16 = sh16;
        end
    end

    // error against the saturated code scaled back up
    assign o_err = acc - (sat8 <<< pcmrq_pkg::SHIFT8);
    assign c8    = sat8[7:0];
    assign c16   = sat16[15:0];

    always_comb begin
        case (i_cfg.fmt)
            pcmrq_pkg::FMT_S8:       o_code = {8'h00, c8};
            pcmrq_pkg::FMT_U8:       o_code = {8'h00, c8 ^ pcmrq_pkg::OFFSET8};
            pcmrq_pkg::FMT_S16:      o_code = c16;
            pcmrq_pkg::FMT_U16:      o_code = c16 ^ pcmrq_pkg::OFFSET16;
            pcmrq_pkg::FMT_S16_SWAP: o_code = {c16[7:0], c16[15:8]};
            pcmrq_pkg::FMT_U16_SWAP: o_code = {c16[7:0], c16[15:8] ^ pcmrq_pkg::OFFSET16[15:8]};
            default:                 o_code = c16;
        endcase
    end

endmodule
